// File: rtl/staged_countdown_sequencer_macros.svh
// ----------------------------------------------------------------------------
// staged countdown sequencer assertion macros
// clocked assertion shorthands shared by the sequencer rtl
// ----------------------------------------------------------------------------
`ifndef STAGED_COUNTDOWN_SEQUENCER_MACROS_SVH
`define STAGED_COUNTDOWN_SEQUENCER_MACROS_SVH

// expression holds at every clock edge out of reset
`define SCS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define SCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// constants, control word format and microcode rom for the countdown sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package scs_pkg;

  localparam int MAX_STAGES        = 3;
  localparam int MAX_STAGE_MINUTES = 480;
  localparam int SECS_PER_MIN      = 60;

  localparam int MIN_W     = 9;
  localparam int SECS_W    = 15;
  localparam int TOTAL_W   = 17;
  localparam int STAGE_W   = 2;
  localparam int TIME_W    = 32;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = MIN_W;
  localparam int OUT_DATA_W = 40;
  localparam int PC_W      = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_ONE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_TWO   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_THREE = 2'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK     = 2'd0,
    KIND_START    = 2'd1,
    KIND_COMPLETE = 2'd2,
    KIND_RESET    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD_ELAPSED,
    OP_CROSS,
    OP_TRIM,
    OP_NEXT_STAMP,
    OP_START,
    OP_SET_ERR,
    OP_CLEAR,
    OP_TOT_INIT,
    OP_TOT_ADD,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_ADV,
    COND_LOOP_DONE,
    COND_IS_TICK,
    COND_NO_PLAN,
    COND_RUNNING,
    COND_SUM_DONE
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            done;
  } ctrl_word_t;

  // program addresses
  localparam logic [PC_W-1:0] A_ADV_CHK   = 4'd0;
  localparam logic [PC_W-1:0] A_LOAD_EL   = 4'd1;
  localparam logic [PC_W-1:0] A_LOOP      = 4'd2;
  localparam logic [PC_W-1:0] A_CROSS     = 4'd3;
  localparam logic [PC_W-1:0] A_TRIM      = 4'd4;
  localparam logic [PC_W-1:0] A_KIND_CHK  = 4'd5;
  localparam logic [PC_W-1:0] A_CPL_NEXT  = 4'd6;
  localparam logic [PC_W-1:0] A_START_CHK = 4'd7;
  localparam logic [PC_W-1:0] A_RUN_CHK   = 4'd8;
  localparam logic [PC_W-1:0] A_START     = 4'd9;
  localparam logic [PC_W-1:0] A_ERR       = 4'd10;
  localparam logic [PC_W-1:0] A_CLEAR     = 4'd11;
  localparam logic [PC_W-1:0] A_TOT_INIT  = 4'd12;
  localparam logic [PC_W-1:0] A_SUM_CHK   = 4'd13;
  localparam logic [PC_W-1:0] A_SUM_ADD   = 4'd14;
  localparam logic [PC_W-1:0] A_EMIT      = 4'd15;

  function automatic ctrl_word_t cw(input op_t op, input cond_t cond,
                                    input logic [PC_W-1:0] target, input logic done);
    ctrl_word_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.done   = done;
    return w;
  endfunction

  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    case (pc)
      A_ADV_CHK:   w = cw(OP_NOP,          COND_NO_ADV,    A_KIND_CHK, 1'b0);
      A_LOAD_EL:   w = cw(OP_LOAD_ELAPSED, COND_NONE,      A_LOOP,     1'b0);
      A_LOOP:      w = cw(OP_NOP,          COND_LOOP_DONE, A_TRIM,     1'b0);
      A_CROSS:     w = cw(OP_CROSS,        COND_ALWAYS,    A_LOOP,     1'b0);
      A_TRIM:      w = cw(OP_TRIM,         COND_NONE,      A_KIND_CHK, 1'b0);
      A_KIND_CHK:  w = cw(OP_NOP,          COND_IS_TICK,   A_TOT_INIT, 1'b0);
      A_CPL_NEXT:  w = cw(OP_NEXT_STAMP,   COND_ALWAYS,    A_TOT_INIT, 1'b0);
      A_START_CHK: w = cw(OP_NOP,          COND_NO_PLAN,   A_ERR,      1'b0);
      A_RUN_CHK:   w = cw(OP_NOP,          COND_RUNNING,   A_TOT_INIT, 1'b0);
      A_START:     w = cw(OP_START,        COND_ALWAYS,    A_TOT_INIT, 1'b0);
      A_ERR:       w = cw(OP_SET_ERR,      COND_ALWAYS,    A_TOT_INIT, 1'b0);
      A_CLEAR:     w = cw(OP_CLEAR,        COND_NONE,      A_TOT_INIT, 1'b0);
      A_TOT_INIT:  w = cw(OP_TOT_INIT,     COND_NONE,      A_SUM_CHK,  1'b0);
      A_SUM_CHK:   w = cw(OP_NOP,          COND_SUM_DONE,  A_EMIT,     1'b0);
      A_SUM_ADD:   w = cw(OP_TOT_ADD,      COND_ALWAYS,    A_SUM_CHK,  1'b0);
      A_EMIT:      w = cw(OP_EMIT,         COND_NONE,      A_EMIT,     1'b1);
      default:     w = cw(OP_EMIT,         COND_NONE,      A_EMIT,     1'b1);
    endcase
    return w;
  endfunction

  // program entry point for each request kind
  function automatic logic [PC_W-1:0] entry_pc(input kind_t kind);
    logic [PC_W-1:0] pc;
    case (kind)
      KIND_START: pc = A_START_CHK;
      KIND_RESET: pc = A_CLEAR;
      default:    pc = A_ADV_CHK;
    endcase
    return pc;
  endfunction

  // stage length in seconds, minutes clamped to the legal range
  function automatic logic [SECS_W-1:0] stage_secs(input logic [MIN_W-1:0] minutes);
    logic [MIN_W-1:0] m;
    m = minutes;
    if (m == '0) begin
      m = MIN_W'(1);
    end
    if (m > MIN_W'(MAX_STAGE_MINUTES)) begin
      m = MIN_W'(MAX_STAGE_MINUTES);
    end
    return SECS_W'(m) * SECS_W'(SECS_PER_MIN);
  endfunction

endpackage

`default_nettype wire

// File: rtl/staged_countdown_sequencer.sv
// ----------------------------------------------------------------------------
// staged countdown sequencer
// microcoded countdown over a plan of up to three timed stages
// ----------------------------------------------------------------------------
// the result register loads at the emit step of the control program, which
//   takes two steps per stage crossing and two per later stage summed into
//   the total
// throughput: one request in flight; the next is taken the cycle after emit
// reset: synchronous rst clears countdown state, stage count to 0 and each
//   stage to one minute; no clearing pass
`default_nettype none

`include "staged_countdown_sequencer_macros.svh"

module staged_countdown_sequencer (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // request stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [scs_pkg::TIME_W-1:0]     s_axis_tdata,  // time in seconds
  input  wire logic [scs_pkg::KIND_W-1:0]     s_axis_tuser,  // kind
  // result stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // status, stage_index, seconds_left, is_running, is_finished, total_left, pad
  output logic [scs_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [scs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [scs_pkg::CFG_DATA_W-1:0] cfg_data
);

  import scs_pkg::*;

  // configuration registers
  logic [STAGE_W-1:0] stage_count;
  logic [MIN_W-1:0]   stage_min [MAX_STAGES];

  // countdown state
  logic [STAGE_W-1:0] active_stage;
  logic [SECS_W-1:0]  stage_remaining;
  logic [TIME_W-1:0]  last_timestamp;
  logic               running;
  logic               finished;

  // sequencer and datapath scratch
  logic               busy;
  logic [PC_W-1:0]    pc;
  kind_t              kind_q;
  logic [TIME_W-1:0]  now_q;
  logic               status;
  logic [TIME_W-1:0]  elapsed;
  logic [TOTAL_W-1:0] total;
  logic [STAGE_W:0]   sum_idx;

  ctrl_word_t         ctrl;
  logic               cond_true;
  logic [STAGE_W-1:0] plan_len;
  logic [STAGE_W:0]   act_inc;
  logic               plan_ends;
  logic [STAGE_W:0]   secs_idx;
  logic [MIN_W-1:0]   secs_min;
  logic [SECS_W-1:0]  secs;
  logic               out_free;
  logic               emit;
  logic               in_req;
  logic               cfg_req;

  assign s_axis_tready = !busy;
  assign cfg_ready     = !busy;
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign cfg_req       = cfg_valid && cfg_ready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign emit          = busy && ctrl.done && out_free;

  // control word for the current step
  assign ctrl = ucode_rom(pc);

  // stage count above the plan limit folds to the limit
  assign plan_len = (stage_count > STAGE_W'(MAX_STAGES)) ? STAGE_W'(MAX_STAGES) : stage_count;

  // next stage index and whether moving to it ends the plan
  assign act_inc   = {1'b0, active_stage} + (STAGE_W+1)'(1);
  assign plan_ends = act_inc >= {1'b0, plan_len};

  // one shared stage length lookup, index picked by the operation
  always_comb begin
    case (ctrl.op)
      OP_START:                 secs_idx = finished ? '0 : {1'b0, active_stage};
      OP_CROSS, OP_NEXT_STAMP:  secs_idx = act_inc;
      OP_TOT_INIT:              secs_idx = {1'b0, active_stage};
      default:                  secs_idx = sum_idx;
    endcase
  end

  // indexes past the configured registers read as a one minute stage
  always_comb begin
    if (secs_idx < (STAGE_W+1)'(MAX_STAGES)) begin
      secs_min = stage_min[secs_idx[STAGE_W-1:0]];
    end else begin
      secs_min = MIN_W'(1);
    end
  end

  assign secs = stage_secs(secs_min);

  // jump condition decode
  always_comb begin
    unique case (ctrl.cond)
      COND_NONE:      cond_true = 1'b0;
      COND_ALWAYS:    cond_true = 1'b1;
      COND_NO_ADV:    cond_true = !running || (now_q <= last_timestamp);
      COND_LOOP_DONE: cond_true = !running || (elapsed < TIME_W'(stage_remaining));
      COND_IS_TICK:   cond_true = kind_q == KIND_TICK;
      COND_NO_PLAN:   cond_true = plan_len == '0;
      COND_RUNNING:   cond_true = running;
      COND_SUM_DONE:  cond_true = (plan_len == '0) || finished ||
                                  (sum_idx >= {1'b0, plan_len});
      default:        cond_true = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_count     <= '0;
      for (int i = 0; i < MAX_STAGES; i++) begin
        stage_min[i] <= MIN_W'(1);
      end
      active_stage    <= '0;
      stage_remaining <= '0;
      last_timestamp  <= '0;
      running         <= 1'b0;
      finished        <= 1'b0;
      busy            <= 1'b0;
      pc              <= '0;
      status          <= 1'b0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      // result register loads at emit, else empties on its handshake
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      // register writes are dropped while a plan runs
      if (cfg_req && !running) begin
        case (cfg_index)
          REG_STAGE_COUNT: begin
            stage_count     <= cfg_data[STAGE_W-1:0];
            active_stage    <= '0;
            stage_remaining <= '0;
            finished        <= 1'b0;
          end
          REG_STAGE_ONE:   stage_min[0] <= cfg_data;
          REG_STAGE_TWO:   stage_min[1] <= cfg_data;
          REG_STAGE_THREE: stage_min[2] <= cfg_data;
          default: ;
        endcase
      end

      if (!busy) begin
        if (in_req) begin
          busy   <= 1'b1;
          kind_q <= kind_t'(s_axis_tuser);
          now_q  <= s_axis_tdata;
          status <= 1'b0;
          pc     <= entry_pc(kind_t'(s_axis_tuser));
        end
      end else begin
        // datapath operation of this step
        case (ctrl.op)
          OP_LOAD_ELAPSED: begin
            elapsed        <= now_q - last_timestamp;
            last_timestamp <= now_q;
          end
          OP_CROSS: begin
            elapsed <= elapsed - TIME_W'(stage_remaining);
            active_stage <= act_inc[STAGE_W-1:0];
            if (plan_ends) begin
              stage_remaining <= '0;
              running         <= 1'b0;
              finished        <= 1'b1;
            end else begin
              stage_remaining <= secs;
            end
          end
          OP_TRIM: begin
            // loop exit leaves elapsed below the remaining time
            if (running) begin
              stage_remaining <= stage_remaining - elapsed[SECS_W-1:0];
            end
          end
          OP_NEXT_STAMP: begin
            // complete: skip to the next stage, stamp even when time went back
            if (running) begin
              active_stage   <= act_inc[STAGE_W-1:0];
              last_timestamp <= now_q;
              if (plan_ends) begin
                stage_remaining <= '0;
                running         <= 1'b0;
                finished        <= 1'b1;
              end else begin
                stage_remaining <= secs;
              end
            end
          end
          OP_START: begin
            // restart from the first stage after a finished plan
            if (finished) begin
              active_stage <= '0;
              finished     <= 1'b0;
            end
            stage_remaining <= secs;
            last_timestamp  <= now_q;
            running         <= 1'b1;
          end
          OP_SET_ERR: status <= 1'b1;
          OP_CLEAR: begin
            active_stage    <= '0;
            stage_remaining <= '0;
            last_timestamp  <= '0;
            running         <= 1'b0;
            finished        <= 1'b0;
          end
          OP_TOT_INIT: begin
            // idle plan counts the active stage at full length
            if ((plan_len == '0) || finished) begin
              total <= '0;
            end else if (running) begin
              total <= TOTAL_W'(stage_remaining);
            end else begin
              total <= TOTAL_W'(secs);
            end
            sum_idx <= act_inc;
          end
          OP_TOT_ADD: begin
            total   <= total + TOTAL_W'(secs);
            sum_idx <= sum_idx + (STAGE_W+1)'(1);
          end
          OP_EMIT: begin
            if (out_free) begin
              m_axis_tdata  <= {3'b000, total, finished, running, stage_remaining,
                                active_stage, status};
            end
          end
          default: ;
        endcase

        // step counter: hold on a full result register at the last step
        if (ctrl.done) begin
          if (out_free) begin
            busy <= 1'b0;
          end
        end else if (cond_true) begin
          pc <= ctrl.target;
        end else begin
          pc <= pc + PC_W'(1);
        end
      end
    end
  end

  `SCS_ASSERT_ALWAYS(a_run_fin_excl, !(running && finished), "running and finished both set")
  `SCS_ASSERT_ALWAYS(a_run_left, !running || (stage_remaining != '0), "running with no time left")
  `SCS_ASSERT_ALWAYS(a_run_stage, !running || (active_stage < plan_len), "stage beyond plan")
  `SCS_ASSERT_NEXT(a_emit, busy && ctrl.done && out_free, m_axis_tvalid && !busy, "emit lost")

endmodule

`default_nettype wire
